// ----- hdl/pgs_pkg.sv -----
`timescale 1ns / 1ps

package pgs_pkg;

   localparam int VFRAC     = 30;
   localparam int V_W       = 31;
   localparam int SQ_W      = 62;
   localparam int NORM_W    = 32;
   localparam int REM_W     = 33;
   localparam int LOG_STEPS = 30;
   localparam int Q_W       = 25;
   localparam int K_W       = 6;
   localparam int NL_W      = 36;
   localparam int LP_W      = 63;
   localparam int L_W       = 37;
   localparam int XP_W      = 62;
   localparam int X2_W      = 48;
   localparam int ROOT_W    = 24;
   localparam int PROD_W    = 56;
   localparam int MAG_W     = 36;
   localparam int SUM_W     = 38;

   localparam logic [26:0]     TWO_LN2_Q26 = 27'd93032640;
   localparam logic [SQ_W-1:0] W_ONE       = SQ_W'(1) << 60;
   localparam logic [K_W-1:0]  W_ONE_EXP   = K_W'(60);

   typedef struct packed {
      logic signed [31:0] mean;
      logic [31:0]        std;
      logic               neg;
   } pgs_side_type;

endpackage

// ----- hdl/pgs_sqrt.sv -----
`timescale 1ns / 1ps

module pgs_sqrt
   import pgs_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  logic [X2_W-1:0]     in_x,
   input  pgs_side_type        in_side,
   output logic                out_valid,
   output logic [ROOT_W-1:0]   out_root,
   output pgs_side_type        out_side
);

   localparam int SR_W = ROOT_W + 2;

   logic                v_ff    [0:ROOT_W];
   logic [X2_W-1:0]     x_ff    [0:ROOT_W];
   logic [SR_W-1:0]     rem_ff  [0:ROOT_W];
   logic [ROOT_W-1:0]   root_ff [0:ROOT_W];
   pgs_side_type        side_ff [0:ROOT_W];

   assign v_ff[0]    = in_valid;
   assign x_ff[0]    = in_x;
   assign rem_ff[0]  = '0;
   assign root_ff[0] = '0;
   assign side_ff[0] = in_side;

   for (genvar i = 0; i < ROOT_W; i++) begin : g_step
      logic [SR_W+1:0]   pre;
      logic [SR_W+1:0]   trial;
      logic              take;
      logic [SR_W-1:0]   rem_in;
      logic [ROOT_W-1:0] root_in;

      assign pre     = {rem_ff[i], x_ff[i][X2_W-1-2*i -: 2]};
      assign trial   = (SR_W+2)'({root_ff[i], 2'b01});
      assign take    = (pre >= trial);
      assign rem_in  = take ? SR_W'(pre - trial) : SR_W'(pre);
      assign root_in = {root_ff[i][ROOT_W-2:0], take};

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i+1] <= 1'b0;
         end else if (en) begin
            v_ff[i+1] <= v_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[i+1]    <= x_ff[i];
            rem_ff[i+1]  <= rem_in;
            root_ff[i+1] <= root_in;
            side_ff[i+1] <= side_ff[i];
         end
      end
   end

   assign out_valid = v_ff[ROOT_W];
   assign out_root  = root_ff[ROOT_W];
   assign out_side  = side_ff[ROOT_W];

`ifndef SYNTHESIS
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      v_ff[ROOT_W] |-> (SR_W+1)'(rem_ff[ROOT_W]) <= (SR_W+1)'({root_ff[ROOT_W], 1'b0}))
      else $error("sqrt remainder exceeds 2*root");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(root_ff[ROOT_W]))
      else $error("sqrt output moved during stall");
   a_first: assert property (@(posedge clock) disable iff (reset)
      v_ff[1] |-> root_ff[1][ROOT_W-1:1] == '0)
      else $error("sqrt first step root too wide");
`endif

endmodule

// ----- hdl/polar_gaussian_sampler.sv -----
`timescale 1ns / 1ps

// Marsaglia polar normal sampler. One request per cycle, passed through these stages
// from request to response: 5 front stages (draw mapping, squares, radius, normalization),
// 30 log2 squaring stages that also carry a 25-step divider, 3 stages for the log scale
// and product, 24 square-root stages and 2 output stages. A pair on or outside the unit
// circle, or at its center, is dropped and gives no response. The whole pipeline holds
// while a response waits on rsp_ready.
module polar_gaussian_sampler
   import pgs_pkg::*;
#(
   parameter int UNIFORM_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [UNIFORM_BITS-1:0]  req_uniform_a,
   input  logic [UNIFORM_BITS-1:0]  req_uniform_b,
   input  logic signed [31:0]       req_mean_value,
   input  logic [31:0]              req_std_dev,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [31:0]       rsp_sample,
   output logic                     rsp_saturated
);

   function automatic logic [V_W-1:0] to_v(input logic [UNIFORM_BITS-1:0] raw);
      logic [UNIFORM_BITS:0] two_u;
      logic [UNIFORM_BITS:0] one;
      logic [UNIFORM_BITS:0] mag;
      two_u = {raw, 1'b0};
      one   = {1'b1, {UNIFORM_BITS{1'b0}}};
      mag   = raw[UNIFORM_BITS-1] ? (two_u - one) : (one - two_u);
      if (UNIFORM_BITS <= VFRAC) begin
         return V_W'(mag) << (VFRAC - UNIFORM_BITS);
      end else begin
         return V_W'(mag >> (UNIFORM_BITS - VFRAC));
      end
   endfunction

   function automatic logic [K_W-1:0] top_bit(input logic [SQ_W-1:0] w);
      logic [K_W-1:0] k;
      k = '0;
      for (int i = 0; i < SQ_W; i++) begin
         if (w[i]) begin
            k = K_W'(i);
         end
      end
      return k;
   endfunction

   logic en;
   logic rsp_valid_ff;

   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;

   // front stages
   logic               v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic [V_W-1:0]     a1_ff, b1_ff;
   logic [SQ_W-1:0]    a2_ff, b2_ff, a3_ff, w3_ff, a4_ff, w4_ff;
   logic [K_W-1:0]     k4_ff, k5_ff;
   logic [NORM_W-1:0]  wn5_ff, vn5_ff;
   pgs_side_type       s1_ff, s2_ff, s3_ff, s4_ff, s5_ff;
   logic [SQ_W-1:0]    w3_in;

   assign w3_in = a2_ff + b2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff && (w3_in != '0) && (w3_in < W_ONE);
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a1_ff      <= to_v(req_uniform_a);
         b1_ff      <= to_v(req_uniform_b);
         s1_ff.mean <= req_mean_value;
         s1_ff.std  <= req_std_dev;
         s1_ff.neg  <= !req_uniform_a[UNIFORM_BITS-1];
         a2_ff      <= a1_ff * a1_ff;
         b2_ff      <= b1_ff * b1_ff;
         s2_ff      <= s1_ff;
         a3_ff      <= a2_ff;
         w3_ff      <= w3_in;
         s3_ff      <= s2_ff;
         a4_ff      <= a3_ff;
         w4_ff      <= w3_ff;
         k4_ff      <= top_bit(w3_ff);
         s4_ff      <= s3_ff;
         wn5_ff     <= NORM_W'({w4_ff, 31'b0} >> k4_ff);
         vn5_ff     <= NORM_W'({a4_ff, 31'b0} >> k4_ff);
         k5_ff      <= k4_ff;
         s5_ff      <= s4_ff;
      end
   end

   // log2 by repeated squaring, with the V1^2/W divider alongside
   logic               lv_ff   [0:LOG_STEPS];
   logic [V_W-1:0]     lm_ff   [0:LOG_STEPS];
   logic [V_W-2:0]     lf_ff   [0:LOG_STEPS];
   logic [REM_W-1:0]   lr_ff   [0:LOG_STEPS];
   logic [NORM_W-1:0]  ld_ff   [0:LOG_STEPS];
   logic [Q_W-1:0]     lq_ff   [0:LOG_STEPS];
   logic [K_W-1:0]     lk_ff   [0:LOG_STEPS];
   pgs_side_type       ls_ff   [0:LOG_STEPS];

   assign lv_ff[0] = v5_ff;
   assign lm_ff[0] = wn5_ff[NORM_W-1:1];
   assign lf_ff[0] = '0;
   assign lr_ff[0] = REM_W'(vn5_ff);
   assign ld_ff[0] = wn5_ff;
   assign lq_ff[0] = '0;
   assign lk_ff[0] = k5_ff;
   assign ls_ff[0] = s5_ff;

   for (genvar i = 0; i < LOG_STEPS; i++) begin : g_log
      logic [2*V_W-1:0]  sq;
      logic [NORM_W-1:0] sqs;
      logic [V_W-1:0]    m_in;
      logic [V_W-2:0]    f_in;
      logic [REM_W-1:0]  r_in;
      logic [Q_W-1:0]    q_in;

      assign sq   = lm_ff[i] * lm_ff[i];
      assign sqs  = sq[2*V_W-1:VFRAC];
      assign m_in = sqs[NORM_W-1] ? sqs[NORM_W-1:1] : sqs[V_W-1:0];
      assign f_in = lf_ff[i] | ((V_W-1)'(sqs[NORM_W-1]) << (LOG_STEPS-1-i));

      if (i < Q_W) begin : g_div
         logic [REM_W-1:0] rs;
         logic             qb;
         if (i == 0) begin : g_first
            assign rs = lr_ff[i];
         end else begin : g_next
            assign rs = lr_ff[i] << 1;
         end
         assign qb   = (rs >= REM_W'(ld_ff[i]));
         assign r_in = qb ? (rs - REM_W'(ld_ff[i])) : rs;
         assign q_in = lq_ff[i] | (Q_W'(qb) << (Q_W-1-i));
      end else begin : g_pass
         assign r_in = lr_ff[i];
         assign q_in = lq_ff[i];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            lv_ff[i+1] <= 1'b0;
         end else if (en) begin
            lv_ff[i+1] <= lv_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            lm_ff[i+1] <= m_in;
            lf_ff[i+1] <= f_in;
            lr_ff[i+1] <= r_in;
            ld_ff[i+1] <= ld_ff[i];
            lq_ff[i+1] <= q_in;
            lk_ff[i+1] <= lk_ff[i];
            ls_ff[i+1] <= ls_ff[i];
         end
      end
   end

   // -2 ln W, then the squared magnitude
   logic               vn_ff, vl_ff, vx_ff;
   logic [NL_W-1:0]    nl_ff;
   logic [L_W-1:0]     l30_ff;
   logic [X2_W-1:0]    x2_ff;
   logic [Q_W-1:0]     qn_ff, ql_ff;
   pgs_side_type       sn_ff, sl_ff, sx_ff;
   logic [LP_W-1:0]    lp;
   logic [LP_W-1:0]    lpr;
   logic [XP_W-1:0]    xp;

   assign lp  = nl_ff * TWO_LN2_Q26;
   assign lpr = lp + (LP_W'(1) << 25);
   assign xp  = ql_ff * l30_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vn_ff <= 1'b0;
         vl_ff <= 1'b0;
         vx_ff <= 1'b0;
      end else if (en) begin
         vn_ff <= lv_ff[LOG_STEPS];
         vl_ff <= vn_ff;
         vx_ff <= vl_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         nl_ff  <= {W_ONE_EXP - lk_ff[LOG_STEPS], 30'b0} - NL_W'(lf_ff[LOG_STEPS]);
         qn_ff  <= lq_ff[LOG_STEPS];
         sn_ff  <= ls_ff[LOG_STEPS];
         l30_ff <= lpr[LP_W-1:26];
         ql_ff  <= qn_ff;
         sl_ff  <= sn_ff;
         x2_ff  <= xp[XP_W-1:14];
         sx_ff  <= sl_ff;
      end
   end

   logic               vr;
   logic [ROOT_W-1:0]  root;
   pgs_side_type       sr;

   pgs_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (vx_ff),
      .in_x      (x2_ff),
      .in_side   (sx_ff),
      .out_valid (vr),
      .out_root  (root),
      .out_side  (sr)
   );

   // scale by std, add mean, saturate
   logic               vp_ff;
   logic [PROD_W-1:0]  prod_ff;
   pgs_side_type       sp_ff;
   logic [PROD_W-1:0]  prod_r;
   logic [MAG_W-1:0]   mag;
   logic signed [SUM_W-1:0] mean_x;
   logic signed [SUM_W-1:0] sum;
   logic               sat_hi, sat_lo;
   logic signed [31:0] sample_ff;
   logic               saturated_ff;

   assign prod_r = prod_ff + (PROD_W'(1) << 19);
   assign mag    = prod_r[PROD_W-1:20];
   assign mean_x = SUM_W'(sp_ff.mean);
   assign sum    = sp_ff.neg ? (mean_x - $signed({2'b00, mag}))
                             : (mean_x + $signed({2'b00, mag}));
   assign sat_hi = !sum[SUM_W-1] && (|sum[SUM_W-2:31]);
   assign sat_lo = sum[SUM_W-1] && !(&sum[SUM_W-2:31]);

   always_ff @(posedge clock) begin
      if (reset) begin
         vp_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         vp_ff        <= vr;
         rsp_valid_ff <= vp_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff      <= root * sr.std;
         sp_ff        <= sr;
         saturated_ff <= sat_hi || sat_lo;
         if (sat_hi) begin
            sample_ff <= 32'sh7fffffff;
         end else if (sat_lo) begin
            sample_ff <= 32'sh80000000;
         end else begin
            sample_ff <= sum[31:0];
         end
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_sample    = sample_ff;
   assign rsp_saturated = saturated_ff;

`ifndef SYNTHESIS
   a_radius: assert property (@(posedge clock) disable iff (reset)
      v3_ff |-> (w3_ff != '0) && (w3_ff < W_ONE))
      else $error("pair outside unit circle passed the reject stage");
   a_norm: assert property (@(posedge clock) disable iff (reset)
      v5_ff |-> wn5_ff[NORM_W-1])
      else $error("radius not normalized");
   a_quot: assert property (@(posedge clock) disable iff (reset)
      vn_ff |-> (!qn_ff[Q_W-1] || (qn_ff[Q_W-2:0] == '0)))
      else $error("quotient above one");
   a_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |-> (rsp_sample == 32'sh7fffffff ||
                                      rsp_sample == 32'sh80000000))
      else $error("saturated flag without clipped sample");
   a_stall: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(x2_ff) && $stable(nl_ff))
      else $error("pipeline moved during stall");
`endif

endmodule

// ----- verif/tb_polar_gaussian_sampler.sv -----
`timescale 1ns / 1ps

module tb_polar_gaussian_sampler;

   localparam int  UBITS      = 16;
   localparam int  CYCLE_LIMIT = 400000;
   localparam int  DRAIN_WAIT  = 100;
   localparam logic [63:0] UNIT_W = 64'd1 << 60;

   typedef struct {
      logic signed [31:0] sample;
      logic               saturated;
   } sample_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic [UBITS-1:0]        req_uniform_a = '0;
   logic [UBITS-1:0]        req_uniform_b = '0;
   logic signed [31:0]      req_mean_value = '0;
   logic [31:0]             req_std_dev = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic signed [31:0]      rsp_sample;
   logic                    rsp_saturated;

   sample_type samples_due[$];
   int      mismatches = 0;
   int      cycles = 0;
   bit      idling_on = 1'b1;
   int      stall_left = 0;

   polar_gaussian_sampler #(.UNIFORM_BITS(UBITS)) dut (.*);

   always #10 clock = ~clock;

   function automatic logic [63:0] int_sqrt(input logic [63:0] x);
      logic [63:0] res;
      logic [63:0] bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (x >= res + bitv) begin
            x = x - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic logic [63:0] shift_signed(input logic [63:0] x, input int sh);
      if (sh >= 0) return (sh >= 64) ? 64'd0 : x << sh;
      return (-sh >= 64) ? 64'd0 : x >> (-sh);
   endfunction

   // returns 0 when the pair is rejected
   function automatic bit gaussian_sample(input logic [UBITS-1:0] ua,
                                          input logic [UBITS-1:0] ub,
                                          input logic signed [31:0] mean,
                                          input logic [31:0] sd, output sample_type res);
      logic [63:0] one, two_a, two_b, va, vb, a2, w, m, f, nl, l30, wn, vn, c, x2, r, mag;
      logic signed [63:0] sum;
      bit neg_a;
      int k;
      one   = 64'd1 << UBITS;
      two_a = {47'd0, ua, 1'b0};
      two_b = {47'd0, ub, 1'b0};
      neg_a = two_a < one;
      va = (neg_a ? one - two_a : two_a - one) << (30 - UBITS);
      vb = ((two_b < one) ? one - two_b : two_b - one) << (30 - UBITS);
      a2 = va * va;
      w  = a2 + vb * vb;
      res.sample = '0;
      res.saturated = 1'b0;
      if (w == 0 || w >= UNIT_W) return 0;
      k = 0;
      m = w;
      while (m > 1) begin
         m = m >> 1;
         k++;
      end
      m = shift_signed(w, 30 - k);
      f = 0;
      for (int i = 0; i < 30; i++) begin
         m = (m * m) >> 30;
         if (m >= (64'd1 << 31)) begin
            m = m >> 1;
            f = f | (64'd1 << (29 - i));
         end
      end
      nl  = (64'(60 - k) << 30) - f;
      l30 = (nl * 64'd93032640 + (64'd1 << 25)) >> 26;
      wn  = shift_signed(w, 31 - k);
      vn  = shift_signed(a2, 31 - k);
      c   = (vn << 32) / wn;
      x2  = ((c >> 8) * l30) >> 14;
      r   = int_sqrt(x2);
      mag = (r * {32'd0, sd} + (64'd1 << 19)) >> 20;
      sum = neg_a ? 64'(mean) - signed'(mag) : 64'(mean) + signed'(mag);
      if (sum > 64'sd2147483647) begin
         sum = 64'sd2147483647;
         res.saturated = 1'b1;
      end else if (sum < -64'sd2147483648) begin
         sum = -64'sd2147483648;
         res.saturated = 1'b1;
      end
      res.sample = sum[31:0];
      return 1;
   endfunction

   task automatic send_request(input logic [UBITS-1:0] ua, input logic [UBITS-1:0] ub,
                               input logic signed [31:0] mean, input logic [31:0] sd);
      sample_type exp_res;
      if (idling_on && $urandom_range(0, 3) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 13)) @(negedge clock);
      end
      req_valid      = 1'b1;
      req_uniform_a  = ua;
      req_uniform_b  = ub;
      req_mean_value = mean;
      req_std_dev    = sd;
      do @(posedge clock); while (!req_ready);
      if (gaussian_sample(ua, ub, mean, sd, exp_res)) samples_due.push_back(exp_res);
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic send_random(input int count);
      logic [31:0] sd;
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(0, 3))
            0: sd = $urandom;
            1: sd = $urandom_range(0, 32'h0010_0000);
            default: sd = $urandom_range(0, 32'h0400_0000);
         endcase
         send_request(UBITS'($urandom), UBITS'($urandom), $urandom, sd);
      end
   endtask

   task automatic wait_drained();
      while (samples_due.size() != 0) @(negedge clock);
   endtask

   task automatic test_directed();
      send_request(16'h0000, 16'h8000, 32'sd0, 32'h0001_0000);       // on the circle
      send_request(16'hFFFF, 16'hFFFF, 32'sd0, 32'h0001_0000);       // outside
      send_request(16'h8000, 16'h8000, 32'sd5, 32'hFFFF_FFFF);       // center
      send_request(16'h8000, 16'hC000, 32'sh1234_5678, 32'hFFFF_FFFF); // V1 zero
      send_request(16'h8001, 16'h8000, 32'sd0, 32'h0001_0000);       // tiny W
      send_request(16'h7FFF, 16'h8000, 32'sd0, 32'h0001_0000);
      send_request(16'h0001, 16'h8000, 32'sd0, 32'h0001_0000);       // W near one
      send_request(16'hFFFF, 16'h8000, 32'sd0, 32'hFFFF_FFFF);
      send_request(16'hC000, 16'hC000, 32'h7FFF_FFFF, 32'hFFFF_FFFF); // high clip
      send_request(16'h4000, 16'h4000, 32'h8000_0000, 32'hFFFF_FFFF); // low clip
      send_request(16'hC000, 16'h4000, 32'h8000_0000, 32'h0000_0000);
      send_request(16'h4000, 16'hC000, 32'h7FFF_FFFF, 32'h0000_0001);
      send_request(16'hA000, 16'h6000, 32'hFFFF_FFFF, 32'h0003_0000);
      send_request(16'h5555, 16'hAAAA, 32'h5555_5555, 32'hAAAA_AAAA);
      send_request(16'hAAAA, 16'h5555, 32'hAAAA_AAAA, 32'h5555_5555);
   endtask

   task automatic test_random_stream();
      send_random(900);
   endtask

   task automatic test_pause_until_drained();
      send_random(50);
      wait_drained();
      send_random(50);
   endtask

   task automatic test_full_rate();
      idling_on = 1'b0;
      send_random(400);
   endtask

   always @(negedge clock) begin
      if (!idling_on) begin
         rsp_ready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 12);
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      sample_type exp_res;
      if (!reset && rsp_valid && rsp_ready) begin
         if (samples_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response: sample %h sat %b", rsp_sample, rsp_saturated);
         end else begin
            exp_res = samples_due.pop_front();
            if (rsp_sample !== exp_res.sample || rsp_saturated !== exp_res.saturated) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp sample %h sat %b, got sample %h sat %b",
                           exp_res.sample, exp_res.saturated, rsp_sample, rsp_saturated);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_random_stream();
      test_pause_until_drained();
      test_full_rate();
      wait_drained();
      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatches == 0 && samples_due.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
